// File: src/mewd_pkg.sv
// Package: shared types, character codes and decode functions for the encoded-word decoder.
`timescale 1ns / 1ps

package mewd_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int BUNDLE_MAX = 4;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [6:0] SX_NONE  = 7'd64;
    localparam logic [6:0] SX_PLUS  = 7'd62;
    localparam logic [6:0] SX_SLASH = 7'd63;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [1:0] HEX_IDLE = 2'd0;
    localparam logic [1:0] HEX_HIGH = 2'd1;
    localparam logic [1:0] HEX_LOW  = 2'd2;

    localparam logic MODE_B64 = 1'b0;
    localparam logic MODE_QP  = 1'b1;

    typedef enum logic [3:0] {
        PH_OPEN_EQ  = 4'd0,
        PH_OPEN_Q   = 4'd1,
        PH_CHARSET  = 4'd2,
        PH_MODE     = 4'd3,
        PH_MODE_SEP = 4'd4,
        PH_PAYLOAD  = 4'd5,
        PH_CLOSE    = 4'd6,
        PH_TEXT     = 4'd7,
        PH_STOPPED  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]                 count;
        res_t [BUNDLE_MAX-1:0]      res;
    } bundle_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        sextet_of = SX_NONE;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
            sextet_of = {1'b0, t[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h61 + 8'd26;
            sextet_of = {1'b0, t[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30 + 8'd52;
            sextet_of = {1'b0, t[5:0]};
        end else if (c == CH_PLUS) begin
            sextet_of = SX_PLUS;
        end else if (c == CH_SLASH) begin
            sextet_of = SX_SLASH;
        end
    endfunction

    function automatic logic [3:0] hex_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            t = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h41:8'h46]}) begin
            t = c - 8'h41 + 8'd10;
        end
        hex_of = t[3:0];
    endfunction

endpackage

// File: src/mewd_front.sv
// Front end: accepts header bytes, runs the word parser and builds one result bundle per byte.
`timescale 1ns / 1ps

module mewd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  mewd_pkg::in_item_t byte_item,
    input  logic               q_full,
    output logic               push,
    output mewd_pkg::bundle_t  bundle
);
    import mewd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        mode_reg, mode_next;
    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pad_reg, pad_next;
    logic [1:0]  hex_reg, hex_next;
    logic [3:0]  hi_reg, hi_next;

    logic             accept;
    logic [7:0]       b;
    logic             eom;
    logic [6:0]       sx;
    logic [3:0]       hx;
    logic             bad;
    logic [1:0]       dn;
    logic [3:0][7:0]  d_bytes;
    logic             tr_en;
    logic [1:0]       tr_kind;

    assign accept = byte_valid && !q_full;
    assign b      = byte_item.in_byte;
    assign eom    = byte_item.end_of_message;
    assign sx     = sextet_of(b);
    assign hx     = hex_of(b);

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        hex_next   = hex_reg;
        hi_next    = hi_reg;
        bad        = 1'b0;
        dn         = 2'd0;
        d_bytes    = '0;
        tr_en      = 1'b0;
        tr_kind    = KIND_DATA;

        case (phase_reg)
            PH_OPEN_EQ:
            begin
                if (b == CH_EQ) phase_next = PH_OPEN_Q;
                else bad = 1'b1;
            end
            PH_OPEN_Q:
            begin
                if (b == CH_QMARK) phase_next = PH_CHARSET;
                else bad = 1'b1;
            end
            PH_CHARSET:
            begin
                if (b == CH_QMARK) phase_next = PH_MODE;
            end
            PH_MODE:
            begin
                if (b == CH_B) begin
                    mode_next  = MODE_B64;
                    phase_next = PH_MODE_SEP;
                end else if (b == CH_Q) begin
                    mode_next  = MODE_QP;
                    phase_next = PH_MODE_SEP;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_MODE_SEP:
            begin
                acc_next   = '0;
                cnt_next   = '0;
                pad_next   = '0;
                hex_next   = HEX_IDLE;
                hi_next    = '0;
                phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (b == CH_QMARK || (mode_reg == MODE_B64 && b == CH_EQ && pad_reg == 2'd0))
                begin
                    // flush a partial base64 group
                    if (mode_reg == MODE_B64 && cnt_reg == 2'd2) begin
                        dn         = 2'd1;
                        d_bytes[0] = acc_reg[11:4];
                    end else if (mode_reg == MODE_B64 && cnt_reg == 2'd3) begin
                        dn         = 2'd2;
                        d_bytes[0] = acc_reg[17:10];
                        d_bytes[1] = acc_reg[9:2];
                    end
                    acc_next = '0;
                    cnt_next = '0;
                    hex_next = HEX_IDLE;
                    hi_next  = '0;
                end
                if (b == CH_QMARK) begin
                    phase_next = PH_CLOSE;
                end else if (mode_reg == MODE_B64) begin
                    if (b == CH_EQ) begin
                        if (pad_reg != 2'd3) pad_next = pad_reg + 2'd1;
                    end else if (sx != SX_NONE && pad_reg == 2'd0) begin
                        if (cnt_reg == 2'd3) begin
                            dn         = 2'd3;
                            d_bytes[0] = acc_reg[17:10];
                            d_bytes[1] = acc_reg[9:2];
                            d_bytes[2] = {acc_reg[1:0], sx[5:0]};
                            acc_next   = '0;
                            cnt_next   = '0;
                        end else begin
                            acc_next = {acc_reg[11:0], sx[5:0]};
                            cnt_next = cnt_reg + 2'd1;
                        end
                    end
                end else begin
                    if (hex_reg == HEX_HIGH) begin
                        hi_next  = hx;
                        hex_next = HEX_LOW;
                    end else if (hex_reg == HEX_LOW) begin
                        dn         = 2'd1;
                        d_bytes[0] = {hi_reg, hx};
                        hex_next   = HEX_IDLE;
                        hi_next    = '0;
                    end else if (b == CH_EQ) begin
                        hex_next = HEX_HIGH;
                    end else if (b == CH_UNDER) begin
                        dn         = 2'd1;
                        d_bytes[0] = CH_SPACE;
                    end else begin
                        dn         = 2'd1;
                        d_bytes[0] = b;
                    end
                end
            end
            PH_CLOSE:
            begin
                phase_next = PH_TEXT;
            end
            PH_TEXT:
            begin
                if (b == CH_EQ) begin
                    phase_next = PH_OPEN_Q;
                end else begin
                    dn         = 2'd1;
                    d_bytes[0] = b;
                end
            end
            default:
            begin
                phase_next = PH_STOPPED;
            end
        endcase

        if (bad) begin
            tr_en      = 1'b1;
            tr_kind    = KIND_BAD;
            phase_next = PH_STOPPED;
        end else if (eom) begin
            if (phase_next == PH_PAYLOAD) begin
                // no bytes came out of this step when a partial group is still pending
                if (mode_next == MODE_B64 && cnt_next == 2'd2) begin
                    dn         = 2'd1;
                    d_bytes[0] = acc_next[11:4];
                end else if (mode_next == MODE_B64 && cnt_next == 2'd3) begin
                    dn         = 2'd2;
                    d_bytes[0] = acc_next[17:10];
                    d_bytes[1] = acc_next[9:2];
                end
                tr_en   = 1'b1;
                tr_kind = KIND_END;
            end else if (phase_next == PH_CLOSE || phase_next == PH_TEXT) begin
                tr_en   = 1'b1;
                tr_kind = KIND_END;
            end else if (phase_next inside {PH_OPEN_EQ, PH_OPEN_Q, PH_CHARSET, PH_MODE,
                                            PH_MODE_SEP}) begin
                tr_en   = 1'b1;
                tr_kind = KIND_BAD;
            end
        end

        if (eom) begin
            phase_next = PH_OPEN_EQ;
            mode_next  = MODE_B64;
            acc_next   = '0;
            cnt_next   = '0;
            pad_next   = '0;
            hex_next   = HEX_IDLE;
            hi_next    = '0;
        end
    end

    always_comb
    begin
        bundle.count = {1'b0, dn} + {2'b00, tr_en};
        for (int i = 0; i < BUNDLE_MAX; i++) begin
            if (3'(i) < {1'b0, dn}) begin
                bundle.res[i].out_byte = d_bytes[i];
                bundle.res[i].kind     = KIND_DATA;
            end else if (3'(i) == {1'b0, dn} && tr_en) begin
                bundle.res[i].out_byte = 8'h00;
                bundle.res[i].kind     = tr_kind;
            end else begin
                bundle.res[i].out_byte = 8'h00;
                bundle.res[i].kind     = KIND_DATA;
            end
        end
    end

    assign push = accept && (bundle.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_OPEN_EQ;
            mode_reg  <= MODE_B64;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            pad_reg   <= '0;
            hex_reg   <= HEX_IDLE;
            hi_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            pad_reg   <= pad_next;
            hex_reg   <= hex_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

// File: src/mewd_queue.sv
// Bundle queue between parser and result serializer.
`timescale 1ns / 1ps

module mewd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mewd_pkg::bundle_t push_data,
    input  logic              pop,
    output mewd_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);
    import mewd_pkg::*;

    bundle_t            mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

// File: src/mewd_back.sv
// Back end: walks the head bundle one result per cycle, while not stalled, into the output register.
`timescale 1ns / 1ps

module mewd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mewd_pkg::bundle_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output mewd_pkg::out_item_t result_item
);
    import mewd_pkg::*;

    localparam int IDX_W = $clog2(BUNDLE_MAX);

    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    out_item_t        item_reg;
    logic             load;
    logic             at_end;

    assign load   = !valid_reg || !result_stall;
    assign at_end = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop    = load && !empty && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= !empty;
            if (!empty) begin
                if (at_end) idx_reg <= '0;
                else        idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty) begin
            item_reg.out_byte <= head.res[idx_reg].out_byte;
            item_reg.kind     <= head.res[idx_reg].kind;
            item_reg.last     <= at_end;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

// File: src/mime_encoded_word_decoder_core.sv
// Top level of the MIME encoded-word decoder: parser, bundle queue and result serializer.
//
//  channel   signals                                     dir  carries
//  byte      byte_valid, byte_stall, byte_item            in   raw header byte + end mark
//  result    result_valid, result_stall, result_item      out  data byte or end/stop code
//
// One header byte is taken per cycle while the bundle queue has room.
// Each byte yields zero to four results; the serializer sends one per cycle unless stalled,
// so the output side sets the sustained rate when words expand.
// Each result is registered in the bundle queue and then in the output register.
// Reset clears parser state and the queue at once; no clearing pass.
// byte_stall rises only when the four-entry queue is full.
`timescale 1ns / 1ps

module mime_encoded_word_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  mewd_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output mewd_pkg::out_item_t result_item
);
    import mewd_pkg::*;

    bundle_t push_bundle, head;
    logic    push, pop, empty, full;

    assign byte_stall = full;

    mewd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .q_full     (full),
        .push       (push),
        .bundle     (push_bundle)
    );

    mewd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    mewd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// File: src/mewd_checker.sv
// Port-level checks for the encoded-word decoder and their bind to the top level.
`timescale 1ns / 1ps

module mewd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input mewd_pkg::out_item_t result_item
);
    import mewd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result request changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.kind != 2'd3)
        else $error("undefined result kind");

    a_code_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.kind != KIND_DATA |->
            result_item.last && result_item.out_byte == 8'h00)
        else $error("end or stop code not final or not zero");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_item.last |=> result_valid)
        else $error("gap inside the results of one byte");

endmodule

bind mime_encoded_word_decoder_core mewd_checker u_mewd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
